FILE: hw/rtl/hwdbt_pkg.sv
// ----------------------------------------------------------------------------
// hwdbt_pkg
// Shared types, constants and helpers for the windowed DFT bin term block.
// ----------------------------------------------------------------------------
package hwdbt_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_DIR_X          = 3'd0,
    REG_DIR_Y          = 3'd1,
    REG_DIR_Z          = 3'd2,
    REG_BIN_INDEX      = 3'd3,
    REG_TOTAL_STEPS    = 3'd4,
    REG_WINDOW_SIZE    = 3'd5,
    REG_REAL_COMPONENT = 3'd6
  } cfg_idx_e;

  // Sine polynomial coefficients, Q30
  localparam logic [30:0] SIN_C1  = 31'd1686629713;
  localparam logic [30:0] SIN_C3  = 31'd693598668;
  localparam logic [30:0] SIN_C5  = 31'd85569306;
  localparam logic [30:0] SIN_C7  = 31'd5026995;
  localparam logic [30:0] SIN_C9  = 31'd172272;
  localparam logic [30:0] Q30_ONE = 31'd1073741824;

  localparam int unsigned NUM_W     = 31;          // widest phase numerator (b*s)
  localparam int unsigned DIV_STEPS = NUM_W + 32;  // integer part plus 32 fraction bits
  localparam int unsigned LANES     = 6;           // sine polynomial stages
  localparam int unsigned PROJ_W    = 34;          // projection, Q.22

  // Projection and flags traveling beside the phase work
  typedef struct packed {
    logic signed [PROJ_W-1:0] proj;
    logic                     in_window;
    logic                     past_end;
  } pay_t;

  // One sine lane stage: argument, its square, polynomial accumulator, sign
  typedef struct packed {
    logic [30:0] x;
    logic [30:0] x2;
    logic [30:0] p;
    logic        neg;
  } lane_t;

  // One restoring division step: {quotient bit, remainder}
  function automatic logic [16:0] div_step(logic [15:0] rem, logic bit_in,
                                           logic [15:0] den);
    logic [16:0] r2;
    r2 = {rem, bit_in};
    if (r2 >= {1'b0, den}) begin
      div_step = {1'b1, 16'(r2 - {1'b0, den})};
    end else begin
      div_step = {1'b0, r2[15:0]};
    end
  endfunction

  // Horner step: c - (p * x2 >> 30)
  function automatic logic [30:0] poly_step(logic [30:0] p, logic [30:0] x2,
                                            logic [30:0] c);
    logic [61:0] m;
    m = 62'(p) * 62'(x2);
    poly_step = c - m[60:30];
  endfunction

  // Coefficient used by lane stage j
  function automatic logic [30:0] poly_const(int j);
    case (j)
      2:       poly_const = SIN_C7;
      3:       poly_const = SIN_C5;
      4:       poly_const = SIN_C3;
      5:       poly_const = SIN_C1;
      default: poly_const = SIN_C9;
    endcase
  endfunction

endpackage

FILE: hw/rtl/hann_windowed_dft_bin_term_top.sv
// ----------------------------------------------------------------------------
// hann_windowed_dft_bin_term_top
// Hann-windowed DFT bin term of a velocity projection, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   Configuration: write cfg_wdata_i to register cfg_idx_i while cfg_we_i is
//   high; writes take effect at once and must only happen with no
//   transaction in flight.
//   Input: a transaction is taken at each clock edge with start high and
//   busy low. busy stays low, so one step enters every cycle.
//   Output: done_o marks each result for exactly one cycle; results leave in
//   input order, one per input, from the input register through the
//   63-stage restoring divider that forms both phases (one quotient bit per
//   stage), six sine polynomial stages and five multiply/round stages.
//   Throughput is one transaction per cycle.
//   The receiver cannot stall; results must be taken when done_o is high.
//   Reset clears all valid bits and loads the register defaults; items in
//   flight are dropped.
// ----------------------------------------------------------------------------
module hann_windowed_dft_bin_term_top #(
  parameter int unsigned TRIG_FRAC_BITS = 15
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [15:0]        cfg_wdata_i,
  // input transaction
  input  logic               start,
  output logic               busy,
  input  logic [15:0]        step_number_i,
  input  logic signed [15:0] vel_x_i,
  input  logic signed [15:0] vel_y_i,
  input  logic signed [15:0] vel_z_i,
  // result
  output logic               done_o,
  output logic signed [31:0] term_value_o,
  output logic               in_window_o,
  output logic               past_end_o
);
  import hwdbt_pkg::*;

  localparam int unsigned FB      = TRIG_FRAC_BITS;
  localparam int unsigned TW      = FB + 2;          // signed trig / hann
  localparam int unsigned M1W     = PROJ_W + TW;     // proj * hann
  localparam int unsigned TWD     = M1W - FB + 1;    // rounded Q.22
  localparam int unsigned M2W     = TWD + TW;        // t * trig
  localparam int unsigned RW      = M2W - FB - 5;    // rounded Q16.16 magnitude
  localparam int unsigned LATENCY = 1 + DIV_STEPS + LANES + 5;

  localparam logic [RW-1:0] POS_LIM = RW'(64'h7FFF_FFFF);
  localparam logic [RW-1:0] NEG_LIM = RW'(64'h8000_0000);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic signed [15:0] dir_x_q, dir_y_q, dir_z_q;
  logic [14:0]        bin_index_q;
  logic [15:0]        total_steps_q, window_size_q;
  logic               real_component_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_x_q          <= 16'sd0;
      dir_y_q          <= 16'sd16384;
      dir_z_q          <= 16'sd0;
      bin_index_q      <= 15'd1;
      total_steps_q    <= 16'd1000;
      window_size_q    <= 16'd300;
      real_component_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        REG_DIR_X:          dir_x_q          <= cfg_wdata_i;
        REG_DIR_Y:          dir_y_q          <= cfg_wdata_i;
        REG_DIR_Z:          dir_z_q          <= cfg_wdata_i;
        REG_BIN_INDEX:      bin_index_q      <= cfg_wdata_i[14:0];
        REG_TOTAL_STEPS:    total_steps_q    <= cfg_wdata_i;
        REG_WINDOW_SIZE:    window_size_q    <= cfg_wdata_i;
        REG_REAL_COMPONENT: real_component_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // --------------------------------------------------------------------------
  // Stage 0: window offset, flags, bin numerator, projection products
  // --------------------------------------------------------------------------
  logic [17:0]        offset;
  logic               s0_vld_q;
  logic [NUM_W-1:0]   s0_nh_q, s0_nb_q;
  logic signed [31:0] s0_px_q, s0_py_q, s0_pz_q;
  logic               s0_inwin_q, s0_past_q;

  assign offset = {2'b00, step_number_i} - {2'b00, total_steps_q} + {2'b00, window_size_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else begin
      s0_vld_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_inwin_q <= !offset[17];
    s0_past_q  <= step_number_i > total_steps_q;
    s0_nh_q    <= offset[17] ? '0 : NUM_W'(offset[16:0]);
    s0_nb_q    <= NUM_W'(bin_index_q) * NUM_W'(step_number_i);
    s0_px_q    <= 32'(vel_x_i) * 32'(dir_x_q);
    s0_py_q    <= 32'(vel_y_i) * 32'(dir_y_q);
    s0_pz_q    <= 32'(vel_z_i) * 32'(dir_z_q);
  end

  // --------------------------------------------------------------------------
  // Phase divider: floor((num mod d) * 2^32 / d), one bit per stage
  // --------------------------------------------------------------------------
  logic             dv_vld_q [DIV_STEPS];
  logic [NUM_W-1:0] dv_nh_q  [DIV_STEPS];
  logic [NUM_W-1:0] dv_nb_q  [DIV_STEPS];
  logic [15:0]      dv_rh_q  [DIV_STEPS];
  logic [15:0]      dv_rb_q  [DIV_STEPS];
  logic [31:0]      dv_qh_q  [DIV_STEPS];
  logic [31:0]      dv_qb_q  [DIV_STEPS];
  pay_t             dv_pay_q [DIV_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    logic             vld_in;
    logic [NUM_W-1:0] nh_in, nb_in;
    logic [15:0]      rh_in, rb_in;
    logic [31:0]      qh_in, qb_in;
    pay_t             pay_in;
    logic [16:0]      st_h, st_b;

    if (k == 0) begin : g_first
      assign vld_in         = s0_vld_q;
      assign nh_in          = s0_nh_q;
      assign nb_in          = s0_nb_q;
      assign rh_in          = '0;
      assign rb_in          = '0;
      assign qh_in          = '0;
      assign qb_in          = '0;
      assign pay_in.proj    = PROJ_W'(s0_px_q) + PROJ_W'(s0_py_q) + PROJ_W'(s0_pz_q);
      assign pay_in.in_window = s0_inwin_q;
      assign pay_in.past_end  = s0_past_q;
    end else begin : g_next
      assign vld_in = dv_vld_q[k-1];
      assign nh_in  = dv_nh_q[k-1];
      assign nb_in  = dv_nb_q[k-1];
      assign rh_in  = dv_rh_q[k-1];
      assign rb_in  = dv_rb_q[k-1];
      assign qh_in  = dv_qh_q[k-1];
      assign qb_in  = dv_qb_q[k-1];
      assign pay_in = dv_pay_q[k-1];
    end

    assign st_h = div_step(rh_in, nh_in[NUM_W-1], window_size_q);
    assign st_b = div_step(rb_in, nb_in[NUM_W-1], total_steps_q);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_vld_q[k] <= 1'b0;
      end else begin
        dv_vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      dv_nh_q[k]  <= nh_in << 1;
      dv_nb_q[k]  <= nb_in << 1;
      dv_rh_q[k]  <= st_h[15:0];
      dv_rb_q[k]  <= st_b[15:0];
      dv_qh_q[k]  <= {qh_in[30:0], st_h[16]};
      dv_qb_q[k]  <= {qb_in[30:0], st_b[16]};
      dv_pay_q[k] <= pay_in;
    end
  end

  // --------------------------------------------------------------------------
  // Sine lanes: quadrant fold, square, Horner steps
  // --------------------------------------------------------------------------
  logic [31:0] ph_h, ph_b, arg_h, arg_b;

  // zero denominator gives phase zero
  assign ph_h  = (window_size_q == '0) ? '0 : dv_qh_q[DIV_STEPS-1];
  assign ph_b  = (total_steps_q == '0) ? '0 : dv_qb_q[DIV_STEPS-1];
  assign arg_h = ph_h + 32'(Q30_ONE);
  assign arg_b = real_component_q ? ph_b + 32'(Q30_ONE) : ph_b;

  logic  ln_vld_q [LANES];
  lane_t ln_h_q   [LANES];
  lane_t ln_b_q   [LANES];
  pay_t  ln_pay_q [LANES];

  for (genvar j = 0; j < LANES; j++) begin : g_lane
    logic  vld_in;
    pay_t  pay_in;
    lane_t h_in, b_in, h_d, b_d;
    logic [61:0] sq_h, sq_b;

    if (j == 0) begin : g_fold
      assign vld_in = dv_vld_q[DIV_STEPS-1];
      assign pay_in = dv_pay_q[DIV_STEPS-1];
      assign h_in   = '0;
      assign b_in   = '0;
      assign sq_h   = '0;
      assign sq_b   = '0;
      always_comb begin
        h_d     = '0;
        b_d     = '0;
        h_d.x   = arg_h[30] ? Q30_ONE - {1'b0, arg_h[29:0]} : {1'b0, arg_h[29:0]};
        h_d.neg = arg_h[31];
        b_d.x   = arg_b[30] ? Q30_ONE - {1'b0, arg_b[29:0]} : {1'b0, arg_b[29:0]};
        b_d.neg = arg_b[31];
      end
    end else if (j == 1) begin : g_square
      assign vld_in = ln_vld_q[j-1];
      assign pay_in = ln_pay_q[j-1];
      assign h_in   = ln_h_q[j-1];
      assign b_in   = ln_b_q[j-1];
      assign sq_h   = 62'(h_in.x) * 62'(h_in.x);
      assign sq_b   = 62'(b_in.x) * 62'(b_in.x);
      always_comb begin
        h_d    = h_in;
        b_d    = b_in;
        h_d.x2 = sq_h[60:30];
        b_d.x2 = sq_b[60:30];
        h_d.p  = SIN_C9;
        b_d.p  = SIN_C9;
      end
    end else begin : g_horner
      assign vld_in = ln_vld_q[j-1];
      assign pay_in = ln_pay_q[j-1];
      assign h_in   = ln_h_q[j-1];
      assign b_in   = ln_b_q[j-1];
      assign sq_h   = '0;
      assign sq_b   = '0;
      always_comb begin
        h_d   = h_in;
        b_d   = b_in;
        h_d.p = poly_step(h_in.p, h_in.x2, poly_const(j));
        b_d.p = poly_step(b_in.p, b_in.x2, poly_const(j));
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ln_vld_q[j] <= 1'b0;
      end else begin
        ln_vld_q[j] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      ln_h_q[j]   <= h_d;
      ln_b_q[j]   <= b_d;
      ln_pay_q[j] <= pay_in;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 6: final multiply by x, clamp, round to FB bits, apply sign
  // --------------------------------------------------------------------------
  function automatic logic signed [TW-1:0] lane_out(lane_t ln);
    logic [61:0]    m;
    logic [30:0]    pv;
    logic [30:0]    rnd;
    logic [TW-1:0]  mag;
    m   = 62'(ln.p) * 62'(ln.x);
    pv  = (m[60:30] > Q30_ONE) ? Q30_ONE : m[60:30];
    rnd = (pv + (31'(1) << (29 - FB))) >> (30 - FB);
    mag = TW'(rnd);
    lane_out = ln.neg ? -mag : mag;
  endfunction

  logic                 s6_vld_q;
  pay_t                 s6_pay_q;
  logic signed [TW-1:0] s6_cos_h_q, s6_trig_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_vld_q <= 1'b0;
    end else begin
      s6_vld_q <= ln_vld_q[LANES-1];
    end
  end

  always_ff @(posedge clk_i) begin
    s6_pay_q   <= ln_pay_q[LANES-1];
    s6_cos_h_q <= lane_out(ln_h_q[LANES-1]);
    s6_trig_q  <= lane_out(ln_b_q[LANES-1]);
  end

  // --------------------------------------------------------------------------
  // Stage 7: Hann value and projection * hann
  // --------------------------------------------------------------------------
  logic signed [PROJ_W-1:0] proj6;
  logic signed [TW:0]       hann_wide;
  logic signed [TW-1:0]     hann;
  logic                     s7_vld_q, s7_inwin_q, s7_past_q;
  logic signed [M1W-1:0]    s7_m1_q;
  logic signed [TW-1:0]     s7_trig_q;

  assign proj6     = s6_pay_q.proj;
  assign hann_wide = ((TW+1)'(1) << FB) - (TW+1)'(s6_cos_h_q);
  assign hann      = TW'(hann_wide >>> 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s7_vld_q <= 1'b0;
    end else begin
      s7_vld_q <= s6_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s7_m1_q    <= M1W'(proj6) * M1W'(hann);
    s7_trig_q  <= s6_trig_q;
    s7_inwin_q <= s6_pay_q.in_window;
    s7_past_q  <= s6_pay_q.past_end;
  end

  // --------------------------------------------------------------------------
  // Stage 8: round to Q.22, ties away from zero
  // --------------------------------------------------------------------------
  logic [M1W-1:0]        m1_mag;
  logic [M1W:0]          m1_sum;
  logic [TWD-1:0]        t_mag;
  logic signed [TWD-1:0] t_d;
  logic                  s8_vld_q, s8_inwin_q, s8_past_q;
  logic signed [TWD-1:0] s8_t_q;
  logic signed [TW-1:0]  s8_trig_q;

  always_comb begin
    m1_mag = s7_m1_q[M1W-1] ? -s7_m1_q : s7_m1_q;
    m1_sum = {1'b0, m1_mag} + ((M1W+1)'(1) << (FB - 1));
    t_mag  = TWD'(m1_sum >> FB);
    t_d    = s7_m1_q[M1W-1] ? -t_mag : t_mag;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s8_vld_q <= 1'b0;
    end else begin
      s8_vld_q <= s7_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s8_t_q     <= t_d;
    s8_trig_q  <= s7_trig_q;
    s8_inwin_q <= s7_inwin_q;
    s8_past_q  <= s7_past_q;
  end

  // --------------------------------------------------------------------------
  // Stage 9: t * trig
  // --------------------------------------------------------------------------
  logic                  s9_vld_q, s9_inwin_q, s9_past_q;
  logic signed [M2W-1:0] s9_m2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s9_vld_q <= 1'b0;
    end else begin
      s9_vld_q <= s8_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s9_m2_q    <= M2W'(s8_t_q) * M2W'(s8_trig_q);
    s9_inwin_q <= s8_inwin_q;
    s9_past_q  <= s8_past_q;
  end

  // --------------------------------------------------------------------------
  // Stage 10: round to Q16.16, saturate, zero outside the window
  // --------------------------------------------------------------------------
  logic [M2W-1:0]     m2_mag;
  logic [M2W:0]       m2_sum;
  logic [RW-1:0]      r_mag;
  logic signed [31:0] term_d;
  logic               done_q, inwin_q, past_q;
  logic signed [31:0] term_q;

  always_comb begin
    m2_mag = s9_m2_q[M2W-1] ? -s9_m2_q : s9_m2_q;
    m2_sum = {1'b0, m2_mag} + ((M2W+1)'(1) << (FB + 5));
    r_mag  = RW'(m2_sum >> (FB + 6));
    if (!s9_inwin_q) begin
      term_d = '0;
    end else if (s9_m2_q[M2W-1]) begin
      term_d = (r_mag > NEG_LIM) ? 32'sh8000_0000 : -32'(r_mag);
    end else begin
      term_d = (r_mag > POS_LIM) ? 32'sh7FFF_FFFF : 32'(r_mag);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= s9_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    term_q  <= term_d;
    inwin_q <= s9_inwin_q;
    past_q  <= s9_past_q;
  end

  assign done_o       = done_q;
  assign term_value_o = term_q;
  assign in_window_o  = inwin_q;
  assign past_end_o   = past_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |-> ##LATENCY done_o)
    else $error("accepted transaction produced no result");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !start |-> ##LATENCY !done_o)
    else $error("result without a matching transaction");

  a_zero_outside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !in_window_o) |-> (term_value_o == 32'sd0))
    else $error("nonzero term outside the window");

  a_past_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && past_end_o) |-> in_window_o)
    else $error("step past the end not flagged inside the window");

endmodule
